/* hdl/asdc_pkg.sv */
// ----------------------------------------------------------------------------
// asdc_pkg
// Shared types, constants and the microcode program of the soft clip core.
// ----------------------------------------------------------------------------
package asdc_pkg;

   localparam int SampleWidth   = 16;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 18;
   localparam int PcWidth       = 4;

   localparam int AWidth    = 33;
   localparam int BWidth    = 19;
   localparam int ProdWidth = AWidth + BWidth;
   localparam int SumWidth  = ProdWidth + 1;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] RegDriveGain    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegClipLevel    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegClipLevelInv = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegMakeupGain   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegWetMix       = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegToneCoef     = 3'd5;

   localparam logic [16:0] DriveGainReset   = 17'd12065;
   localparam logic [14:0] ClipLevelReset   = 15'd17250;
   localparam logic [17:0] ClipLevelInvReset = 18'd62245;
   localparam logic [14:0] MakeupGainReset  = 15'd6173;
   localparam logic [14:0] WetMixReset      = 15'd12288;
   localparam logic [13:0] ToneCoefReset    = 14'd10752;

   localparam logic signed [BWidth-1:0] HpFeedback = 19'sd32604;
   localparam logic signed [BWidth-1:0] RecipThree = 19'sd43691;  // ceil(2^17 / 3)
   localparam logic signed [19:0] ClipRailPos = 20'sd21845;
   localparam logic signed [19:0] ClipRailNeg = -20'sd21845;
   localparam logic signed [SampleWidth-1:0] SampleMax = 16'sh7fff;
   localparam logic signed [SampleWidth-1:0] SampleMin = 16'sh8000;

   typedef struct packed {
      logic [16:0] drive_gain;
      logic [14:0] clip_level;
      logic [17:0] clip_level_inverse;
      logic [14:0] makeup_gain;
      logic [14:0] wet_mix;
      logic [13:0] tone_coefficient;
   } cfg_type;

   typedef enum logic [2:0] {
      A_HPO, A_W, A_V, A_VABS, A_VLPA, A_LPADRY
   } a_sel_type;

   typedef enum logic [3:0] {
      B_HPFB, B_DRIVE, B_INV, B_W, B_RECIP3, B_CLIP3, B_MAKEUP, B_TONE, B_WET
   } b_sel_type;

   typedef enum logic [1:0] {SH_12, SH_15, SH_16, SH_17} shift_type;

   typedef enum logic [2:0] {
      ADD_ZERO, ADD_HPDIFF, ADD_W, ADD_LPA, ADD_DRY
   } add_sel_type;

   typedef enum logic [2:0] {
      DST_NONE, DST_HP, DST_W, DST_V, DST_LPA, DST_OUT
   } dst_type;

   typedef struct packed {
      a_sel_type           a_sel;
      b_sel_type           b_sel;
      shift_type           shift;
      add_sel_type         add_sel;
      dst_type             dst;
      logic                div3;    // signed quotient term subtracted
      logic                branch;  // jump when normalized value hits a rail
      logic                last;
      logic [PcWidth-1:0]  target;
   } ctrl_word_type;

   localparam logic [PcWidth-1:0] StepHp      = 4'd0;
   localparam logic [PcWidth-1:0] StepDrive   = 4'd1;
   localparam logic [PcWidth-1:0] StepNorm    = 4'd2;
   localparam logic [PcWidth-1:0] StepRail    = 4'd3;
   localparam logic [PcWidth-1:0] StepSquare  = 4'd4;
   localparam logic [PcWidth-1:0] StepCube    = 4'd5;
   localparam logic [PcWidth-1:0] StepShape   = 4'd6;
   localparam logic [PcWidth-1:0] StepRescale = 4'd7;
   localparam logic [PcWidth-1:0] StepMakeup  = 4'd8;
   localparam logic [PcWidth-1:0] StepTone    = 4'd9;
   localparam logic [PcWidth-1:0] StepMix     = 4'd10;

   function automatic ctrl_word_type step_word(
      input a_sel_type a, input b_sel_type b, input shift_type sh,
      input add_sel_type ad, input dst_type d, input logic dv,
      input logic br, input logic la, input logic [PcWidth-1:0] tg);
      ctrl_word_type w;
      w.a_sel   = a;
      w.b_sel   = b;
      w.shift   = sh;
      w.add_sel = ad;
      w.dst     = d;
      w.div3    = dv;
      w.branch  = br;
      w.last    = la;
      w.target  = tg;
      return w;
   endfunction

   function automatic ctrl_word_type rom_word(input logic [PcWidth-1:0] pc);
      ctrl_word_type w;
      case (pc)
         StepHp:      w = step_word(A_HPO, B_HPFB, SH_15, ADD_HPDIFF, DST_HP,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepDrive:   w = step_word(A_HPO, B_DRIVE, SH_12, ADD_ZERO, DST_W,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepNorm:    w = step_word(A_W, B_INV, SH_15, ADD_ZERO, DST_W,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepRail:    w = step_word(A_W, B_W, SH_15, ADD_ZERO, DST_NONE,
                                    1'b0, 1'b1, 1'b0, StepRescale);
         StepSquare:  w = step_word(A_W, B_W, SH_15, ADD_ZERO, DST_V,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepCube:    w = step_word(A_V, B_W, SH_15, ADD_ZERO, DST_V,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepShape:   w = step_word(A_VABS, B_RECIP3, SH_17, ADD_W, DST_V,
                                    1'b1, 1'b0, 1'b0, StepHp);
         StepRescale: w = step_word(A_V, B_CLIP3, SH_16, ADD_ZERO, DST_V,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepMakeup:  w = step_word(A_V, B_MAKEUP, SH_12, ADD_ZERO, DST_V,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepTone:    w = step_word(A_VLPA, B_TONE, SH_15, ADD_LPA, DST_LPA,
                                    1'b0, 1'b0, 1'b0, StepHp);
         StepMix:     w = step_word(A_LPADRY, B_WET, SH_15, ADD_DRY, DST_OUT,
                                    1'b0, 1'b0, 1'b1, StepHp);
         default:     w = step_word(A_W, B_W, SH_15, ADD_ZERO, DST_NONE,
                                    1'b0, 1'b0, 1'b1, StepHp);
      endcase
      return w;
   endfunction

endpackage

/* hdl/asdc_seq.sv */
// ----------------------------------------------------------------------------
// asdc_seq
// Step counter and program ROM; one word per cycle, stalled by full output.
// ----------------------------------------------------------------------------
module asdc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   out_free,
   input  logic                   rail_hit,
   output asdc_pkg::ctrl_word_type ctrl,
   output logic                   busy,
   output logic                   exec
);
   import asdc_pkg::*;

   logic [PcWidth-1:0] pc_ff, pc_in;
   logic               busy_ff, busy_in;

   assign ctrl = rom_word(pc_ff);
   assign busy = busy_ff;
   assign exec = busy_ff && (!ctrl.last || out_free);

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = StepHp;
         busy_in = 1'b1;
      end else if (exec) begin
         if (ctrl.last) begin
            busy_in = 1'b0;
         end else if (ctrl.branch && rail_hit) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= StepHp;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* hdl/asdc_dpath.sv */
// ----------------------------------------------------------------------------
// asdc_dpath
// Shared multiply, shift and add datapath with filter state and work registers.
// ----------------------------------------------------------------------------
module asdc_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [asdc_pkg::SampleWidth-1:0] sample_in,
   input  logic                                 last_in,
   input  logic                                 exec,
   input  asdc_pkg::ctrl_word_type              ctrl,
   input  asdc_pkg::cfg_type                    cfg,
   output logic                                 rail_hit,
   output logic signed [asdc_pkg::SampleWidth-1:0] sample_out,
   output logic                                 last_out
);
   import asdc_pkg::*;

   logic signed [15:0] dry_ff;
   logic               eob_ff;
   logic signed [15:0] hli_ff;
   logic signed [31:0] hpo_ff;
   logic signed [31:0] lpa_ff;
   logic signed [31:0] w_ff;
   logic signed [19:0] v_ff;

   logic signed [AWidth-1:0]    a_op;
   logic signed [BWidth-1:0]    b_op;
   logic signed [ProdWidth-1:0] prod;
   logic signed [ProdWidth-1:0] shifted;
   logic signed [ProdWidth-1:0] term;
   logic signed [SumWidth-1:0]  addend;
   logic signed [SumWidth-1:0]  sum;
   logic signed [20:0]          v_abs;
   logic [16:0]                 clip3;
   logic                        rail_hi, rail_lo;

   assign v_abs = v_ff[19] ? -21'(v_ff) : 21'(v_ff);
   assign clip3 = {2'b00, cfg.clip_level} + {1'b0, cfg.clip_level, 1'b0};

   always_comb begin
      case (ctrl.a_sel)
         A_HPO:    a_op = AWidth'(hpo_ff);
         A_W:      a_op = AWidth'(w_ff);
         A_V:      a_op = AWidth'(v_ff);
         A_VABS:   a_op = AWidth'(v_abs);
         A_VLPA:   a_op = AWidth'(v_ff) - AWidth'(lpa_ff);
         A_LPADRY: a_op = AWidth'(lpa_ff) - AWidth'(dry_ff);
         default:  a_op = '0;
      endcase
   end

   always_comb begin
      case (ctrl.b_sel)
         B_HPFB:   b_op = HpFeedback;
         B_DRIVE:  b_op = signed'({2'b00, cfg.drive_gain});
         B_INV:    b_op = signed'({1'b0, cfg.clip_level_inverse});
         B_W:      b_op = BWidth'(signed'(w_ff[16:0]));
         B_RECIP3: b_op = RecipThree;
         B_CLIP3:  b_op = signed'({2'b00, clip3});
         B_MAKEUP: b_op = signed'({4'b0000, cfg.makeup_gain});
         B_TONE:   b_op = signed'({5'b00000, cfg.tone_coefficient});
         B_WET:    b_op = signed'({4'b0000, cfg.wet_mix});
         default:  b_op = '0;
      endcase
   end

   assign prod = a_op * b_op;

   always_comb begin
      case (ctrl.shift)
         SH_12:   shifted = prod >>> 12;
         SH_15:   shifted = prod >>> 15;
         SH_16:   shifted = prod >>> 16;
         SH_17:   shifted = prod >>> 17;
         default: shifted = prod;
      endcase
   end

   // truncating divide: the quotient magnitude takes the sign of the cube
   assign term = (ctrl.div3 && !v_ff[19]) ? -shifted : shifted;

   always_comb begin
      case (ctrl.add_sel)
         ADD_ZERO:   addend = '0;
         ADD_HPDIFF: addend = SumWidth'(dry_ff) - SumWidth'(hli_ff);
         ADD_W:      addend = SumWidth'(w_ff);
         ADD_LPA:    addend = SumWidth'(lpa_ff);
         ADD_DRY:    addend = SumWidth'(dry_ff);
         default:    addend = '0;
      endcase
   end

   assign sum = SumWidth'(term) + addend;

   assign rail_hi  = !w_ff[31] && (|w_ff[30:15]);
   assign rail_lo  = w_ff[31] && !((&w_ff[30:15]) && (|w_ff[14:0]));
   assign rail_hit = rail_hi || rail_lo;

   always_comb begin
      if (sum > SumWidth'(SampleMax)) begin
         sample_out = SampleMax;
      end else if (sum < SumWidth'(SampleMin)) begin
         sample_out = SampleMin;
      end else begin
         sample_out = sum[15:0];
      end
   end
   assign last_out = eob_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         dry_ff <= sample_in;
         eob_ff <= last_in;
      end
      if (exec) begin
         case (ctrl.dst)
            DST_W:   w_ff <= sum[31:0];
            DST_V:   v_ff <= sum[19:0];
            default: ;
         endcase
         if (ctrl.branch && rail_hit) begin
            v_ff <= rail_lo ? ClipRailNeg : ClipRailPos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hli_ff <= '0;
         hpo_ff <= '0;
         lpa_ff <= '0;
      end else if (exec) begin
         case (ctrl.dst)
            DST_HP: begin
               hpo_ff <= sum[31:0];
               hli_ff <= dry_ff;
            end
            DST_LPA: lpa_ff <= sum[31:0];
            default: ;
         endcase
      end
   end

endmodule

/* hdl/audio_soft_clip_distortion_core.sv */
// ----------------------------------------------------------------------------
// audio_soft_clip_distortion_core
// DC blocker, drive, cubic soft clip, makeup gain, tone low-pass and wet/dry mix.
//
//   channel | direction | words
//   req     | in        | tdata: sample_in[15:0]; tlast: end_of_block
//   rsp     | out       | tdata: sample_out[15:0]; tlast: end_of_block_out
//   csr     | in        | index 0..5, data 18 bits; other indexes ignored
//
// A word is accepted, then runs 11 microcode steps on the shared multiplier;
// square, cube and shape are skipped when the normalized value hits a rail.
// A result waiting in the output register lets the next word enter; the mix
// step holds while that register is still full.
// Reset clears filter state and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module audio_soft_clip_distortion_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [15:0]                             req_tdata,   // sample_in[15:0]
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [15:0]                             rsp_tdata,   // sample_out[15:0]
   output logic                                    rsp_tlast,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [asdc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [asdc_pkg::CsrDataWidth-1:0]       csr_data
);
   import asdc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;
   logic             rsp_last_ff;

   ctrl_word_type    seq_ctrl;
   logic             seq_busy;
   logic             seq_exec;
   logic             rail_hit;
   logic             start;
   logic             out_free;
   logic             out_write;
   logic signed [15:0] dp_sample;
   logic             dp_last;

   assign csr_ready  = 1'b1;
   assign req_tready = !seq_busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_write  = seq_exec && (seq_ctrl.dst == DST_OUT);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   asdc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .rail_hit (rail_hit),
      .ctrl     (seq_ctrl),
      .busy     (seq_busy),
      .exec     (seq_exec)
   );

   asdc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .sample_in  (signed'(req_tdata)),
      .last_in    (req_tlast),
      .exec       (seq_exec),
      .ctrl       (seq_ctrl),
      .cfg        (cfg_ff),
      .rail_hit   (rail_hit),
      .sample_out (dp_sample),
      .last_out   (dp_last)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            RegDriveGain:    cfg_in.drive_gain         = csr_data[16:0];
            RegClipLevel:    cfg_in.clip_level         = csr_data[14:0];
            RegClipLevelInv: cfg_in.clip_level_inverse = csr_data[17:0];
            RegMakeupGain:   cfg_in.makeup_gain        = csr_data[14:0];
            RegWetMix:       cfg_in.wet_mix            = csr_data[14:0];
            RegToneCoef:     cfg_in.tone_coefficient   = csr_data[13:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_gain         <= DriveGainReset;
         cfg_ff.clip_level         <= ClipLevelReset;
         cfg_ff.clip_level_inverse <= ClipLevelInvReset;
         cfg_ff.makeup_gain        <= MakeupGainReset;
         cfg_ff.wet_mix            <= WetMixReset;
         cfg_ff.tone_coefficient   <= ToneCoefReset;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_write) begin
         rsp_data_ff <= dp_sample;
         rsp_last_ff <= dp_last;
      end
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> seq_busy)
      else $error("sequencer not busy after accepting a word");

   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(out_write))
      else $error("result valid without a mix step");

   a_mix_holds: assert property (@(posedge clock) disable iff (reset)
      (seq_busy && seq_ctrl.last && !out_free) |=> seq_busy)
      else $error("mix step left while output register full");

   a_exec_busy: assert property (@(posedge clock) disable iff (reset)
      seq_exec |-> (seq_busy && !start))
      else $error("step executed while idle or accepting");
`endif

endmodule

/* verif/audio_soft_clip_distortion_core_test.sv */
// ----------------------------------------------------------------------------
// audio_soft_clip_distortion_core_test
// Self-checking bench for the soft clip distortion core. A directed table runs
// first (silence, full-scale steps, a fully dry mix, extreme and masked
// register values, writes to unused indexes), then random phases with new
// register settings and shaped sample streams. Every result word is checked
// against a bit-exact predictor of the filter chain or a typed expectation,
// under random stalls on both streams.
// ----------------------------------------------------------------------------
module audio_soft_clip_distortion_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import asdc_pkg::*;

   localparam int RegCount       = 6;
   localparam int PhaseCount     = 8;
   localparam int PhaseWords     = 190;
   localparam int PressurePhase  = 3;
   localparam int BurstWords     = 80;
   localparam int LongHoldCycles = 400;
   localparam int SettleCycles   = 16;
   localparam int QuietLimit     = 2000;

   localparam logic [CsrIndexWidth-1:0] BadIndexLow  = 3'd6;
   localparam logic [CsrIndexWidth-1:0] BadIndexHigh = 3'd7;

   localparam longint HighpassFeedback = 32604;
   localparam longint ClipRail         = 21845;
   localparam longint UnityQ15         = 32768;

   localparam int RegLow   [RegCount] = '{4096, 6000, 41297, 4096, 0, 6144};
   localparam int RegHigh  [RegCount] = '{81920, 26000, 178956, 17749, 32000, 14336};
   localparam int RegReset [RegCount] = '{12065, 17250, 62245, 6173, 12288, 10752};

   typedef struct packed {
      logic [15:0] sample;
      logic        last;
   } out_word_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef enum int {
      SHAPE_NOISE, SHAPE_SQUARE, SHAPE_QUIET, SHAPE_RAMP, SHAPE_SPARSE
   } shape_type;

   typedef struct {
      row_kind_type              kind;
      logic signed [15:0]        sample;
      logic                      last;
      logic                      typed;
      logic signed [15:0]        typed_sample;
      logic [CsrIndexWidth-1:0]  index;
      logic [CsrDataWidth-1:0]   value;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [15:0]              req_tdata;   // sample_in[15:0]
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [15:0]              rsp_tdata;   // sample_out[15:0]
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   // typed expectation riding along with the word on the bus
   logic                     note_typed;
   logic signed [15:0]       note_sample;

   cfg_type       shadow_regs;
   longint        hp_in_prev;
   longint        hp_out_prev;
   longint        tone_acc;
   out_word_type  expected_words[$];

   int  error_count;
   int  words_sent;
   int  words_checked;
   int  reg_writes;
   int  rail_hits;
   int  saturations;
   int  long_holds;
   int  quiet_cycles;
   bit  rx_hold_request;

   stim_row_type directed_rows [] = '{
      '{ROW_WORD, 16'sd0,     1'b0, 1'b1, 16'sd0,    '0, '0},  // silence stays silent
      '{ROW_WORD, SampleMax,  1'b1, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMin,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMin,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMax,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, 16'sd1,     1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, -16'sd1,    1'b1, 1'b0, '0,        '0, '0},
      // fully dry: output equals input
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegWetMix, 18'd0},
      '{ROW_WORD, SampleMin,  1'b0, 1'b1, SampleMin, '0, '0},
      '{ROW_WORD, SampleMax,  1'b1, 1'b1, SampleMax, '0, '0},
      '{ROW_WORD, 16'sd0,     1'b0, 1'b1, 16'sd0,    '0, '0},
      '{ROW_WORD, 16'sh5555,  1'b0, 1'b1, 16'sh5555, '0, '0},
      '{ROW_WORD, 16'shaaaa,  1'b1, 1'b1, 16'shaaaa, '0, '0},
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegDriveGain, 18'h1ffff},
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegWetMix, 18'h07fff},
      '{ROW_WORD, SampleMax,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMin,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMax,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, 16'sd100,   1'b1, 1'b0, '0,        '0, '0},
      // all-ones data, upper bits dropped where the register is narrower
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegClipLevel, 18'h3ffff},
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegMakeupGain, 18'h3ffff},
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegClipLevelInv, 18'h3ffff},
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        RegToneCoef, 18'h3ffff},
      '{ROW_WORD, SampleMin,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMin,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMax,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, SampleMax,  1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, 16'sd0,     1'b1, 1'b0, '0,        '0, '0},
      // unused indexes must not touch any register
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        BadIndexLow, 18'h00000},
      '{ROW_CSR,  '0,         1'b0, 1'b0, '0,        BadIndexHigh, 18'h3ffff},
      '{ROW_WORD, 16'sd12345, 1'b0, 1'b0, '0,        '0, '0},
      '{ROW_WORD, -16'sd12345, 1'b1, 1'b0, '0,       '0, '0}
   };

   audio_soft_clip_distortion_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------

   function automatic longint wrap32(input longint v);
      int w;
      w = v[31:0];
      return longint'(w);
   endfunction

   function automatic void apply_reg_write(input logic [CsrIndexWidth-1:0] index,
                                           input logic [CsrDataWidth-1:0] value);
      case (index)
         RegDriveGain:    shadow_regs.drive_gain         = value[16:0];
         RegClipLevel:    shadow_regs.clip_level         = value[14:0];
         RegClipLevelInv: shadow_regs.clip_level_inverse = value[17:0];
         RegMakeupGain:   shadow_regs.makeup_gain        = value[14:0];
         RegWetMix:       shadow_regs.wet_mix            = value[14:0];
         RegToneCoef:     shadow_regs.tone_coefficient   = value[13:0];
         default: ;
      endcase
   endfunction

   function automatic out_word_type distort_sample(input logic signed [15:0] sample,
                                                   input logic last);
      longint dry, hp, driven, norm, sq, cube, clipped, shaped, mix, sum;
      out_word_type r;
      dry = sample;
      hp = wrap32(dry - hp_in_prev + ((hp_out_prev * HighpassFeedback) >>> 15));
      hp_in_prev  = dry;
      hp_out_prev = hp;
      driven = wrap32((hp * longint'(shadow_regs.drive_gain)) >>> 12);
      norm   = wrap32((driven * longint'(shadow_regs.clip_level_inverse)) >>> 15);
      if (norm >= UnityQ15) begin
         clipped = ClipRail;
         rail_hits++;
      end else if (norm <= -UnityQ15) begin
         clipped = -ClipRail;
         rail_hits++;
      end else begin
         sq      = (norm * norm) >>> 15;
         cube    = (sq * norm) >>> 15;
         clipped = norm - cube / 3;
      end
      shaped = (clipped * longint'(shadow_regs.clip_level) * 3) >>> 16;
      shaped = (shaped * longint'(shadow_regs.makeup_gain)) >>> 12;
      tone_acc = wrap32(tone_acc +
                        (((shaped - tone_acc) * longint'(shadow_regs.tone_coefficient)) >>> 15));
      mix = longint'(shadow_regs.wet_mix);
      sum = (dry * (UnityQ15 - mix) + tone_acc * mix) >>> 15;
      if (sum > 32767) begin
         sum = 32767;
         saturations++;
      end else if (sum < -32768) begin
         sum = -32768;
         saturations++;
      end
      r.sample = sum[15:0];
      r.last   = last;
      return r;
   endfunction

   // ---------------- checking ----------------

   always @(posedge clock) begin : scoreboard
      out_word_type want;
      out_word_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_reg_write(csr_index, csr_data);
            reg_writes++;
         end
         if (req_tvalid && req_tready) begin
            want = distort_sample(req_tdata, req_tlast);
            if (note_typed)
               want.sample = note_sample;
            expected_words.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.sample = rsp_tdata;
            got.last   = rsp_tlast;
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: sample_out %0d",
                      $signed(got.sample));
               error_count++;
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (got.sample !== want.sample) begin
                  $error("sample_out: expected %0d, actual %0d",
                         $signed(want.sample), $signed(got.sample));
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("end_of_block_out: expected %0b, actual %0b", want.last, got.last);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QuietLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------- receiver ----------------

   initial begin : receiver
      int n;
      int k;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
            long_holds++;
         end
         n = $urandom_range(1, 40);
         k = $urandom_range(0, 9);
         if (k == 9)
            n = $urandom_range(10, 80);
         repeat (n) begin
            if (k < 4)
               rsp_tready <= 1'b1;
            else if (k < 9)
               rsp_tready <= ($urandom_range(0, 9) < 7);
            else
               rsp_tready <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // ---------------- sender ----------------

   function automatic int gap_length();
      int c;
      c = $urandom_range(0, 99);
      if (c < 55) return 0;
      if (c < 90) return $urandom_range(1, 3);
      if (c < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_word(input logic signed [15:0] sample, input logic last,
                            input logic typed, input logic signed [15:0] typed_sample);
      req_tvalid  <= 1'b1;
      req_tdata   <= sample;
      req_tlast   <= last;
      note_typed  <= typed;
      note_sample <= typed_sample;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic idle_req(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_phase(input int phase);
      logic [CsrDataWidth-1:0] v [RegCount];
      int r;
      int c;
      int level;
      for (r = RegDriveGain; r <= RegToneCoef; r++) begin
         c = $urandom_range(0, 99);
         if (phase == 0 || (phase > 2 && c < 15))
            v[r] = CsrDataWidth'(RegReset[r]);
         else if (phase == 1 || (phase > 2 && c < 30))
            v[r] = CsrDataWidth'(RegLow[r]);
         else if (phase == 2 || (phase > 2 && c < 45))
            v[r] = CsrDataWidth'(RegHigh[r]);
         else if (c < 60)
            v[r] = CsrDataWidth'($urandom);
         else
            v[r] = CsrDataWidth'($urandom_range(RegLow[r], RegHigh[r]));
      end
      level = int'(v[RegClipLevel][14:0]);
      if (phase > 2 && level >= 4096 && $urandom_range(0, 1))
         v[RegClipLevelInv] = CsrDataWidth'((1 << 30) / level);
      for (r = RegDriveGain; r <= RegToneCoef; r++)
         write_reg(CsrIndexWidth'(r), v[r]);
      if (phase > 2 && $urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? BadIndexLow : BadIndexHigh,
                   CsrDataWidth'($urandom));
   endtask

   task automatic play_phase(input int count, input bit pressure);
      int i;
      int left;
      int period;
      int cnt;
      int step;
      bit steady;
      shape_type shape;
      logic signed [15:0] s;
      logic signed [15:0] level;
      left   = 0;
      s      = '0;
      level  = SampleMax;
      period = 1;
      cnt    = 0;
      step   = 1;
      steady = 1'b0;
      shape  = SHAPE_NOISE;
      if (pressure)
         rx_hold_request = 1'b1;
      for (i = 0; i < count; i++) begin
         if (left == 0) begin
            left   = $urandom_range(8, 64);
            shape  = shape_type'($urandom_range(SHAPE_NOISE, SHAPE_SPARSE));
            period = $urandom_range(1, 48);
            step   = $urandom_range(1, 6000);
            steady = ($urandom_range(0, 3) == 0);
            cnt    = 0;
         end
         left--;
         case (shape)
            SHAPE_NOISE:  s = 16'($urandom);
            SHAPE_SQUARE: begin
               if (cnt == period) begin
                  level = (level == SampleMax) ? SampleMin : SampleMax;
                  cnt   = 0;
               end
               cnt++;
               s = level;
            end
            SHAPE_QUIET:  s = 16'($urandom_range(0, 511) - 256);
            SHAPE_RAMP:   s = 16'(s + step);
            default:      s = ($urandom_range(0, 7) == 0) ? 16'($urandom) : '0;
         endcase
         send_word(s, $urandom_range(0, 15) == 0, 1'b0, '0);
         if (!steady && !(pressure && i < BurstWords))
            idle_req(gap_length());
      end
   endtask

   initial begin : stimulus
      int p;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      note_typed  = 1'b0;
      note_sample = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      shadow_regs.drive_gain         = 17'(RegReset[RegDriveGain]);
      shadow_regs.clip_level         = 15'(RegReset[RegClipLevel]);
      shadow_regs.clip_level_inverse = 18'(RegReset[RegClipLevelInv]);
      shadow_regs.makeup_gain        = 15'(RegReset[RegMakeupGain]);
      shadow_regs.wet_mix            = 15'(RegReset[RegWetMix]);
      shadow_regs.tone_coefficient   = 14'(RegReset[RegToneCoef]);
      hp_in_prev  = 0;
      hp_out_prev = 0;
      tone_acc    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain();
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_word(directed_rows[i].sample, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].typed_sample);
            idle_req(gap_length());
         end
      end

      for (p = 0; p < PhaseCount; p++) begin
         drain();
         configure_phase(p);
         play_phase(PhaseWords, p == PressurePhase);
      end
      drain();

      if (expected_words.size() != 0) begin
         $error("%0d expected result words never arrived", expected_words.size());
         error_count++;
      end
      $display("run: %0d words in, %0d results checked, %0d register writes, %0d settings",
               words_sent, words_checked, reg_writes, PhaseCount + 1);
      $display("run: clip rail hit %0d times, mix saturated %0d times, %0d long output holds",
               rail_hits, saturations, long_holds);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
